// ===== hdl/lcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lcm_pkg;

  // Command beat, byte 0 in the low lane.
  typedef struct packed {
    logic [7:0] b3;
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
  } cmd_bytes_t;

  // Mode codes carried in byte 3 bits 7..5.
  localparam logic [2:0] ModeSecondA = 3'd0;
  localparam logic [2:0] ModeFirstA  = 3'd1;
  localparam logic [2:0] ModeMerged  = 3'd4;
  localparam logic [2:0] ModeSecondB = 3'd5;
  localparam logic [2:0] ModeFirstB  = 3'd6;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // One byte of the check. The shift keeps bit 15 (arithmetic shift).
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] r;
    logic        low;
    r = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      low = r[0];
      r   = {r[15], r[15:1]};
      if (low) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

  // Check state after the fixed packet prefix 00 00 01.
  localparam logic [15:0] CrcPrefix = crc_byte(crc_byte(crc_byte(CrcInit, 8'h00), 8'h00), 8'h01);

endpackage

`default_nettype wire

// ===== hdl/lcm_cmd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lcm_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] cmd_byte0;
  logic [7:0] cmd_byte1;
  logic [7:0] cmd_byte2;
  logic [7:0] cmd_byte3;

  modport source (output valid, cmd_byte0, cmd_byte1, cmd_byte2, cmd_byte3, input ready);
  modport sink (input valid, cmd_byte0, cmd_byte1, cmd_byte2, cmd_byte3, output ready);
endinterface

`default_nettype wire

// ===== hdl/lcm_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lcm_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte0;
  logic [7:0]  out_byte1;
  logic [7:0]  out_byte2;
  logic [7:0]  out_byte3;
  logic [15:0] crc_value;

  modport source (output valid, out_byte0, out_byte1, out_byte2, out_byte3, crc_value,
                  input ready);
  modport sink (input valid, out_byte0, out_byte1, out_byte2, out_byte3, crc_value,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/lcm_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcm_merge
  import lcm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire cmd_bytes_t cmd_in,
  output cmd_bytes_t      cmd_out
);

  logic [1:0] led_active;        // bit 0 first LED, bit 1 second LED
  logic [1:0] led_active_next;
  cmd_bytes_t saved_first;
  cmd_bytes_t saved_first_next;
  cmd_bytes_t saved_second;
  cmd_bytes_t saved_second_next;

  logic [2:0] mode;
  logic       hit_first;
  logic       hit_second;
  logic       is_off;
  cmd_bytes_t sel;

  assign mode       = cmd_in.b3[7:5];
  assign hit_first  = (mode == ModeFirstA) || (mode == ModeFirstB);
  assign hit_second = (mode == ModeSecondA) || (mode == ModeSecondB);
  assign is_off     = (cmd_in.b3[4:2] == 3'b000);

  always_comb begin
    led_active_next   = led_active;
    saved_first_next  = saved_first;
    saved_second_next = saved_second;
    sel               = cmd_in;
    if (cmd_in.b0 == 8'h00) begin
      if (is_off) begin
        led_active_next = led_active & ~{hit_second, hit_first};
        if (led_active_next != 2'b00) begin
          sel = (led_active_next == 2'b01) ? saved_first : saved_second;
        end
      end else begin
        led_active_next = led_active | {hit_second, hit_first};
        if (hit_first) begin
          saved_first_next = cmd_in;
        end
        if (hit_second) begin
          saved_second_next = cmd_in;
        end
      end
      // Both lit: blend the two saved commands, mode forced to merged.
      if (led_active_next == 2'b11) begin
        sel.b1 = saved_second_next.b1;
        sel.b2 = {saved_first_next.b2[7:1], saved_second_next.b2[0]};
        sel.b3 = {ModeMerged, sel.b3[4:2], saved_first_next.b3[1:0]};
      end
    end
    cmd_out = sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_active <= 2'b00;
    end else if (accept) begin
      led_active <= led_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      saved_first  <= saved_first_next;
      saved_second <= saved_second_next;
    end
  end

`ifndef ASSERT_OFF
  a_merge_mode: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd_in.b0 == 8'h00) && (led_active_next == 2'b11)
      |-> (cmd_out.b3[7:5] == ModeMerged))
    else $error("merged command without merged mode");

  a_passthru: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd_in.b0 != 8'h00) |=> $stable(led_active))
    else $error("LED state moved on a non-LED command");

  a_off_first: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd_in.b0 == 8'h00) && is_off && hit_first |=> !led_active[0])
    else $error("first LED still lit after its off command");
`endif

endmodule

`default_nettype wire

// ===== hdl/lcm_crc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcm_crc
  import lcm_pkg::*;
(
  input  wire cmd_bytes_t  cmd,
  output logic [15:0]      crc
);

  // Prefix bytes are folded into a constant; the rest collapses to an XOR tree.
  always_comb begin
    crc = crc_byte(crc_byte(crc_byte(CrcPrefix, cmd.b0), cmd.b1), cmd.b2);
  end

endmodule

`default_nettype wire

// ===== hdl/led_command_merge_crc_framer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// LED command merge and check framer.
// cmd (sink): one 4-byte output command per beat. res (source): the final
// 4 command bytes plus the 16-bit packet check over 00 00 01 b0 b1 b2.
// Commands with byte 0 equal to zero go through the LED merge: "off" clears
// the addressed LED and substitutes a still-lit LED's saved command, "on"
// saves the command; with both LEDs lit the saved commands are blended and
// the mode forced to 4. Other commands pass through untouched.
// The merge runs on the incoming beat and lands in a stage register; the
// check is an XOR tree from that register into the output register.
// Throughput: one beat per cycle while res.ready is high, set by the
// two-register pipeline with no shared unit.
// Reset (rst, synchronous): both LEDs inactive, pipeline emptied.
// Stall: while res.ready is low the output beat holds; one more beat is
// taken into the stage register, then cmd.ready drops until res moves.
module led_command_merge_crc_framer
  import lcm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  lcm_cmd_if.sink   cmd,
  lcm_res_if.source res
);

  cmd_bytes_t  cmd_in;
  cmd_bytes_t  merged;
  logic        accept;

  logic        stg_valid;
  cmd_bytes_t  stg;
  logic [15:0] stg_crc;
  logic        stg_adv;

  logic        out_valid;
  cmd_bytes_t  out_bytes;
  logic [15:0] out_crc;

  assign cmd_in  = '{b3: cmd.cmd_byte3, b2: cmd.cmd_byte2, b1: cmd.cmd_byte1,
                     b0: cmd.cmd_byte0};
  assign stg_adv = stg_valid && (!out_valid || res.ready);
  assign cmd.ready = !stg_valid || stg_adv;
  assign accept  = cmd.valid && cmd.ready;

  lcm_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .cmd_in  (cmd_in),
    .cmd_out (merged)
  );

  lcm_crc u_crc (
    .cmd (stg),
    .crc (stg_crc)
  );

  // Stage register: merged command bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (cmd.ready) begin
      stg_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg <= merged;
    end
  end

  // Output register: bytes and check.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || res.ready) begin
      out_valid <= stg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv) begin
      out_bytes <= stg;
      out_crc   <= stg_crc;
    end
  end

  assign res.valid     = out_valid;
  assign res.out_byte0 = out_bytes.b0;
  assign res.out_byte1 = out_bytes.b1;
  assign res.out_byte2 = out_bytes.b2;
  assign res.out_byte3 = out_bytes.b3;
  assign res.crc_value = out_crc;

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !stg_valid && !out_valid)
    else $error("pipeline not empty after reset");

  a_full_take: assert property (@(posedge clk) disable iff (rst)
    accept && stg_valid |-> stg_adv)
    else $error("beat taken into an occupied stage");

  a_adv_out: assert property (@(posedge clk) disable iff (rst)
    stg_adv |=> out_valid)
    else $error("stage moved but no output beat");
`endif

endmodule

`default_nettype wire
